### rtl/art_pkg.sv
`timescale 1ns / 1ps

package art_pkg;

  // Field and time widths.
  localparam int TIME_BITS     = 40;
  localparam int BLEND_STEP_MS = 16;
  localparam int RATE_W        = 17;
  localparam int W_W           = 16;
  localparam int QUOT_BITS     = 16;

  // Rate constants in Q2.14.
  localparam logic [RATE_W-1:0] RATE_ONE   = 17'd16384;
  localparam logic [RATE_W-1:0] RATE_MAX   = 17'd65536;
  localparam logic [RATE_W-1:0] RATE_FLOOR = 17'd819;
  localparam logic [RATE_W-1:0] ROUND_HALF = 17'd32768;

  // Blend weight limits in Q0.16 and the per-millisecond decay in Q0.32.
  localparam logic [W_W-1:0] W_MIN      = 16'd9830;
  localparam logic [W_W-1:0] W_MAX      = 16'd52429;
  localparam logic [63:0]    EXP_ONE_MS = 64'd4287814979;
  localparam logic [63:0]    Q32_ONE    = 64'h0000_0001_0000_0000;
  localparam int             WTAB_LIMIT = 1024;

  // Counter widths of the serial units.
  localparam int CMP_CNT_W = $clog2(TIME_BITS + 1);
  localparam int DIV_CNT_W = $clog2(QUOT_BITS + 1);
  localparam int MUL_CNT_W = $clog2(W_W + 1);

  // Status of the serial compare pass.
  typedef struct packed {
    logic work_lt;
    logic wall_lt;
    logic work_ne;
    logic elapsed_nz;
  } cmp_flags_t;

  // Rounded Q0.32 product.
  function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + 128'h8000_0000;
    return p[95:32];
  endfunction

  // Decay over one table step, built by repeated one-millisecond products.
  function automatic logic [63:0] step_factor();
    logic [63:0] s;
    s = Q32_ONE;
    for (int i = 0; i < BLEND_STEP_MS; i++) begin
      s = q32_mul(s, EXP_ONE_MS);
    end
    return s;
  endfunction

  // Weight entry for a decay value x: round(65536 * (1 - x)), clamped.
  function automatic logic [W_W-1:0] wtab_round(input logic [63:0] x);
    logic [63:0] r;
    r = (Q32_ONE - x + 64'd32768) >> 16;
    if (r < 64'(W_MIN)) r = 64'(W_MIN);
    if (r > 64'(W_MAX)) r = 64'(W_MAX);
    return r[W_W-1:0];
  endfunction

  // Number of entries up to and including the first one at the upper limit.
  function automatic int wtab_count();
    logic [63:0] s;
    logic [63:0] x;
    int          n;
    logic        found;
    s     = step_factor();
    x     = Q32_ONE;
    n     = 0;
    found = 1'b0;
    for (int k = 0; k < WTAB_LIMIT; k++) begin
      if (!found) begin
        n = k + 1;
        if (wtab_round(x) >= W_MAX) found = 1'b1;
        else x = q32_mul(x, s);
      end
    end
    return n;
  endfunction

  localparam int WTAB_COUNT  = wtab_count();
  localparam int WTAB_IDX_W  = (WTAB_COUNT > 1) ? $clog2(WTAB_COUNT) : 1;
  localparam int STEP_LIMIT  = BLEND_STEP_MS * (WTAB_COUNT - 1);
  localparam int EL_W        = (STEP_LIMIT > 0) ? $clog2(STEP_LIMIT + 1) : 1;

  typedef logic [W_W-1:0] wtab_t [WTAB_COUNT];

  function automatic wtab_t wtab_build();
    wtab_t       t;
    logic [63:0] s;
    logic [63:0] x;
    s = step_factor();
    x = Q32_ONE;
    for (int k = 0; k < WTAB_COUNT; k++) begin
      t[k] = wtab_round(x);
      x    = q32_mul(x, s);
    end
    return t;
  endfunction

  localparam wtab_t WTAB = wtab_build();

endpackage

### rtl/art_serial_sub.sv
`timescale 1ns / 1ps

// Bit-serial subtraction of both clock pairs, least significant bit first.
module art_serial_sub (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [art_pkg::TIME_BITS-1:0] work_i,
  input  logic signed [art_pkg::TIME_BITS-1:0] prev_work_i,
  input  logic        [art_pkg::TIME_BITS-1:0] wall_i,
  input  logic        [art_pkg::TIME_BITS-1:0] prev_wall_i,
  output logic                             done_o,
  output art_pkg::cmp_flags_t              flags_o,
  output logic        [art_pkg::TIME_BITS:0]   delta_o,
  output logic        [art_pkg::TIME_BITS-1:0] elapsed_o
);
  import art_pkg::*;

  logic [TIME_BITS-1:0] a_q, b_q, c_q, d_q;
  logic [TIME_BITS-1:0] delta_q, elapsed_q;
  logic                 delta_top_q;
  logic                 bw_work_q, bw_wall_q;
  logic                 bw_work_d, bw_wall_d;
  logic                 dbit_work, dbit_wall, ext_bit;
  cmp_flags_t           flags_q;
  logic [CMP_CNT_W-1:0] cnt_q;
  logic                 done_q;

  always_comb begin
    dbit_work = a_q[0] ^ b_q[0] ^ bw_work_q;
    bw_work_d = (~a_q[0] & b_q[0]) | (~(a_q[0] ^ b_q[0]) & bw_work_q);
    dbit_wall = c_q[0] ^ d_q[0] ^ bw_wall_q;
    bw_wall_d = (~c_q[0] & d_q[0]) | (~(c_q[0] ^ d_q[0]) & bw_wall_q);
    // Sign-extension step of the workout difference: its sign means "less than".
    ext_bit   = a_q[0] ^ b_q[0] ^ bw_work_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CMP_CNT_W'(TIME_BITS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CMP_CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q       <= work_i;
      b_q       <= prev_work_i;
      c_q       <= wall_i;
      d_q       <= prev_wall_i;
      bw_work_q <= 1'b0;
      bw_wall_q <= 1'b0;
      flags_q   <= '0;
    end else if (cnt_q != '0) begin
      a_q                <= a_q >> 1;
      b_q                <= b_q >> 1;
      c_q                <= c_q >> 1;
      d_q                <= d_q >> 1;
      bw_work_q          <= bw_work_d;
      bw_wall_q          <= bw_wall_d;
      delta_q            <= {dbit_work, delta_q[TIME_BITS-1:1]};
      elapsed_q          <= {dbit_wall, elapsed_q[TIME_BITS-1:1]};
      flags_q.work_ne    <= flags_q.work_ne | dbit_work;
      flags_q.elapsed_nz <= flags_q.elapsed_nz | dbit_wall;
      if (cnt_q == CMP_CNT_W'(1)) begin
        flags_q.work_lt <= ext_bit;
        flags_q.wall_lt <= bw_wall_d;
        delta_top_q     <= ext_bit;
      end
    end
  end

  assign done_o    = done_q;
  assign flags_o   = flags_q;
  assign delta_o   = {delta_top_q, delta_q};
  assign elapsed_o = elapsed_q;

endmodule

### rtl/art_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, giving delta / elapsed in
// Q2.14. It saturates at 4.0 when delta is at least four times elapsed.
module art_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [art_pkg::TIME_BITS:0]   delta_i,
  input  logic [art_pkg::TIME_BITS-1:0] elapsed_i,
  output logic                          done_o,
  output logic [art_pkg::RATE_W-1:0]    quot_o
);
  import art_pkg::*;

  localparam int RW = TIME_BITS + 2;

  logic [RW-1:0]        rem_q;
  logic [TIME_BITS-1:0] div_q;
  logic [RATE_W-1:0]    quot_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic                 sat;
  logic [RW-1:0]        twice_div;
  logic [RW-1:0]        rem_sub;
  logic [RW-1:0]        rem_sel;
  logic                 ge;

  always_comb begin
    sat       = {1'b0, delta_i[TIME_BITS:2]} >= elapsed_i;
    twice_div = {1'b0, div_q, 1'b0};
    ge        = rem_q >= twice_div;
    rem_sub   = rem_q - twice_div;
    rem_sel   = ge ? rem_sub : rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (sat) begin
          cnt_q  <= '0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= DIV_CNT_W'(QUOT_BITS);
        end
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, delta_i};
      div_q  <= elapsed_i;
      quot_q <= sat ? RATE_MAX : '0;
    end else if (cnt_q != '0) begin
      rem_q  <= {rem_sel[RW-2:0], 1'b0};
      quot_q <= {quot_q[RATE_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/art_blender.sv
`timescale 1ns / 1ps

// Serial shift-add blend: rate * (1 - w) + measured * w, one weight bit per
// cycle from the most significant end, rounded half up at the end.
module art_blender (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [art_pkg::RATE_W-1:0] rate_i,
  input  logic [art_pkg::RATE_W-1:0] meas_i,
  input  logic [art_pkg::W_W-1:0]    weight_i,
  output logic                       done_o,
  output logic [art_pkg::RATE_W-1:0] blend_o
);
  import art_pkg::*;

  localparam int AW = 2 * W_W + 1;

  logic [W_W-1:0]       wm_q;
  logic [W_W-1:0]       wr_q;
  logic [AW-1:0]        acc_q;
  logic [AW-1:0]        acc_sum;
  logic [AW-1:0]        rounded;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [RATE_W-1:0]    weight_comp;

  always_comb begin
    weight_comp = RATE_MAX - {1'b0, weight_i};
    acc_sum     = {acc_q[AW-2:0], 1'b0}
                + (wm_q[W_W-1] ? AW'(meas_i) : '0)
                + (wr_q[W_W-1] ? AW'(rate_i) : '0);
    rounded     = acc_q + AW'(ROUND_HALF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= MUL_CNT_W'(W_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MUL_CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      wm_q  <= weight_i;
      wr_q  <= weight_comp[W_W-1:0];
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      wm_q  <= {wm_q[W_W-2:0], 1'b0};
      wr_q  <= {wr_q[W_W-2:0], 1'b0};
      acc_q <= acc_sum;
    end
  end

  assign done_o  = done_q;
  assign blend_o = rounded[AW-1:W_W];

endmodule

### rtl/adaptive_rate_tracker.sv
// Flow: one item at a time; the next is accepted the cycle after the result
// is registered, and the result waits in S_EMIT while the output is full.
// Reset: asynchronous, active low; clears control state and loads rate 1.0.
`timescale 1ns / 1ps

// The block follows how fast a workout clock runs against the wall clock.
// Every sample goes through up to three serial units in turn:
//  - a bit-serial pass that subtracts both clock pairs one bit per cycle
//    and yields the deltas plus the "went backwards" and "changed" flags,
//  - a restoring divider that forms the measured ratio one bit per cycle,
//  - a shift-add unit that blends that ratio into the running rate.
// Samples that re-arm, stop, or leave either clock unchanged skip the last
// two units. The result is registered, so a finished item can wait at the
// output while the interface stays well defined.
module adaptive_rate_tracker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [art_pkg::TIME_BITS-1:0] workout_time_ms_i,
  input  logic        [art_pkg::TIME_BITS-1:0] monotonic_time_ms_i,
  input  logic                                 motion_known_i,
  input  logic                                 moving_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [art_pkg::RATE_W-1:0]    rate_o,
  input  logic                                 cfg_we_i,
  input  logic        [art_pkg::RATE_W-1:0]    cfg_wdata_i
);
  import art_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CMP    = 6'b000010,
    S_DECIDE = 6'b000100,
    S_DIV    = 6'b001000,
    S_MUL    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e                      state_q;
  logic                        armed_q;
  logic signed [TIME_BITS-1:0] prev_work_q;
  logic        [TIME_BITS-1:0] prev_wall_q;
  logic        [RATE_W-1:0]    rate_now_q;
  logic        [RATE_W-1:0]    rate_moving_q;
  logic                        out_valid_q;
  logic        [RATE_W-1:0]    out_rate_q;

  // Sample held for the length of its processing.
  logic signed [TIME_BITS-1:0] work_q;
  logic        [TIME_BITS-1:0] wall_q;
  logic                        known_q;
  logic                        moving_q;
  logic        [W_W-1:0]       weight_q;

  logic                        in_accept;
  logic                        cmp_done;
  cmp_flags_t                  flags;
  logic        [TIME_BITS:0]   delta;
  logic        [TIME_BITS-1:0] elapsed;
  logic                        div_start;
  logic                        div_done;
  logic        [RATE_W-1:0]    quot;
  logic                        mul_start;
  logic                        mul_done;
  logic        [RATE_W-1:0]    blend;

  logic                        rearm;
  logic                        stop;
  logic                        go_blend;
  logic        [RATE_W-1:0]    rate_eff;
  logic        [RATE_W-1:0]    cfg_rate;
  logic        [WTAB_IDX_W-1:0] w_idx;

  assign in_accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    // A missing baseline or either clock running backwards starts over.
    rearm    = !armed_q || flags.wall_lt || flags.work_lt;
    stop     = known_q && !moving_q;
    go_blend = !rearm && !stop && flags.work_ne && flags.elapsed_nz;

    // A restart from standstill resumes at the remembered rate, at least 0.05.
    if (known_q && moving_q && (rate_now_q == '0)) begin
      rate_eff = (rate_moving_q > RATE_FLOOR) ? rate_moving_q : RATE_FLOOR;
    end else begin
      rate_eff = rate_now_q;
    end

    cfg_rate = (cfg_wdata_i > RATE_MAX) ? RATE_MAX : cfg_wdata_i;

    // Weight index is elapsed / step, held at the last table entry.
    if (elapsed >= TIME_BITS'(STEP_LIMIT)) begin
      w_idx = WTAB_IDX_W'(WTAB_COUNT - 1);
    end else begin
      w_idx = WTAB_IDX_W'(elapsed[EL_W-1:0] / BLEND_STEP_MS);
    end
  end

  assign div_start = (state_q == S_DECIDE) && go_blend;
  assign mul_start = (state_q == S_DIV) && div_done;

  art_serial_sub u_sub (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .work_i      (workout_time_ms_i),
    .prev_work_i (prev_work_q),
    .wall_i      (monotonic_time_ms_i),
    .prev_wall_i (prev_wall_q),
    .done_o      (cmp_done),
    .flags_o     (flags),
    .delta_o     (delta),
    .elapsed_o   (elapsed)
  );

  art_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .delta_i   (delta),
    .elapsed_i (elapsed),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  art_blender u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .rate_i   (rate_now_q),
    .meas_i   (quot),
    .weight_i (weight_q),
    .done_o   (mul_done),
    .blend_o  (blend)
  );

  // Control state and the tracker's stored values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      armed_q       <= 1'b0;
      prev_work_q   <= '0;
      prev_wall_q   <= '0;
      rate_now_q    <= RATE_ONE;
      rate_moving_q <= RATE_ONE;
      out_valid_q   <= 1'b0;
    end else begin
      // A new result takes the output register as soon as it is free or
      // being emptied; otherwise an accepted result simply leaves it.
      if ((state_q == S_EMIT) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_CMP;
        end
        S_CMP: begin
          if (cmp_done) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          state_q <= go_blend ? S_DIV : S_EMIT;
          if (rearm) begin
            // Negative workout time is stored as zero on re-arm.
            armed_q     <= 1'b1;
            prev_work_q <= work_q[TIME_BITS-1] ? '0 : work_q;
            prev_wall_q <= wall_q;
            if (stop) rate_now_q <= '0;
          end else if (stop) begin
            if (rate_now_q != '0) rate_moving_q <= rate_now_q;
            rate_now_q  <= '0;
            prev_work_q <= work_q;
            prev_wall_q <= wall_q;
          end else begin
            rate_now_q <= rate_eff;
            // Times are kept only when the workout clock actually moved.
            if (flags.work_ne) begin
              prev_work_q <= work_q;
              prev_wall_q <= wall_q;
            end
          end
        end
        S_DIV: begin
          if (div_done) state_q <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            rate_now_q <= blend;
            if (blend != '0) rate_moving_q <= blend;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // Writing the start rate re-arms the tracker.
      if (cfg_we_i) begin
        armed_q       <= 1'b0;
        prev_work_q   <= '0;
        prev_wall_q   <= '0;
        rate_now_q    <= cfg_rate;
        rate_moving_q <= (cfg_rate != '0) ? cfg_rate : RATE_ONE;
      end
    end
  end

  // Sample and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      work_q   <= workout_time_ms_i;
      wall_q   <= monotonic_time_ms_i;
      known_q  <= motion_known_i;
      moving_q <= moving_i;
    end
    if (state_q == S_DECIDE) weight_q <= WTAB[w_idx];
    if ((state_q == S_EMIT) && (!out_valid_q || out_ready_i)) out_rate_q <= rate_now_q;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign rate_o      = out_rate_q;

endmodule

### rtl/art_checker.sv
`timescale 1ns / 1ps

module art_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [art_pkg::RATE_W-1:0] rate_o
);
  import art_pkg::*;

  // An accepted item keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready right after an item was accepted");

  // The input reopens only together with a registered result.
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("input reopened without a result on the output");

  // The rate never leaves 0 to 4.0.
  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rate_o <= RATE_MAX))
    else $error("rate above 4.0");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(rate_o)))
    else $error("stalled result dropped or changed");

endmodule

bind adaptive_rate_tracker art_checker u_art_checker (.*);
